FILE: rtl/core/gcs_pkg.sv
// Shared constants, types and helpers for the G-code comment stripper.
`default_nettype none

package gcs_pkg;

   localparam int unsigned SPACE_DEPTH_DEF = 32;

   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_SEMI    = 8'd59;
   localparam logic [7:0] CH_OPEN    = 8'd40;
   localparam logic [7:0] CH_CLOSE   = 8'd41;

   typedef struct packed {
      logic accept;
      logic rd_en;
      logic load_sp;
      logic load_ch;
      logic load_nl;
   } gcs_cmd_type;

   typedef struct packed {
      logic emit_char;
      logic emit_nl;
      logic has_pending;
      logic last_space;
      logic out_free;
   } gcs_status_type;

   function automatic logic is_blank(input logic [7:0] c);
      return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gcs_ctrl.sv
// Sequencing controller: input transfer, whitespace drain and result loading.
`default_nettype none

module gcs_ctrl
   import gcs_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire gcs_status_type status,
   output gcs_cmd_type         cmd
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_FETCH   = 5'b00010,
      ST_SEND_SP = 5'b00100,
      ST_SEND_CH = 5'b01000,
      ST_SEND_NL = 5'b10000
   } gcs_state_type;

   gcs_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.emit_nl) begin
                  state_in = ST_SEND_NL;
               end else if (status.emit_char && status.has_pending) begin
                  state_in = ST_FETCH;
               end else if (status.emit_char) begin
                  state_in = ST_SEND_CH;
               end
            end
         end
         ST_FETCH: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_SEND_SP;
         end
         ST_SEND_SP: begin
            if (status.out_free) begin
               cmd.load_sp = 1'b1;
               state_in    = status.last_space ? ST_SEND_CH : ST_FETCH;
            end
         end
         ST_SEND_CH: begin
            if (status.out_free) begin
               cmd.load_ch = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_SEND_NL: begin
            if (status.out_free) begin
               cmd.load_nl = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/gcs_dp.sv
// Datapath: line state, held whitespace store and result register.
`default_nettype none

module gcs_dp
   import gcs_pkg::*;
#(
   parameter int unsigned SPACE_DEPTH = SPACE_DEPTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [7:0]   req_in_byte,
   input  wire logic         req_end_of_stream,
   input  wire gcs_cmd_type  cmd,
   output gcs_status_type    status,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_line_end,
   output logic              rsp_overflow,
   output logic              rsp_run_last
);

   localparam int unsigned CNT_W = $clog2(SPACE_DEPTH + 1);
   localparam int unsigned IDX_W = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(SPACE_DEPTH);

   logic [7:0] space_mem [SPACE_DEPTH];

   logic             comment_ff, comment_in;
   logic             paren_ff, paren_in;
   logic             content_ff, content_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       char_ff, char_in;
   logic [7:0]       rd_data_ff;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             end_ff, end_in;
   logic             last_ff, last_in;
   logic             flag_ff, flag_in;

   logic             wr_en;
   logic             emit_char;
   logic             emit_nl;
   logic             out_free;
   logic             load;

   always_comb begin
      comment_in = comment_ff;
      paren_in   = paren_ff;
      content_in = content_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      total_in   = total_ff;
      char_in    = char_ff;
      wr_en      = 1'b0;
      emit_char  = 1'b0;
      emit_nl    = 1'b0;
      if (req_in_byte == CH_NEWLINE) begin
         emit_nl    = content_ff;
         comment_in = 1'b0;
         paren_in   = 1'b0;
         content_in = 1'b0;
         count_in   = '0;
      end else begin
         if (comment_ff) begin
            comment_in = 1'b1;
         end else if (req_in_byte == CH_SEMI) begin
            comment_in = 1'b1;
         end else if (req_in_byte == CH_OPEN) begin
            paren_in = 1'b1;
         end else if (req_in_byte == CH_CLOSE) begin
            paren_in = 1'b0;
         end else if (paren_ff) begin
            paren_in = 1'b1;
         end else if (is_blank(req_in_byte)) begin
            if (content_ff) begin
               if (count_ff < DEPTH_C) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end else begin
            emit_char  = 1'b1;
            total_in   = count_ff;
            count_in   = '0;
            content_in = 1'b1;
            char_in    = req_in_byte;
         end
         if (req_end_of_stream) begin
            comment_in = 1'b0;
            paren_in   = 1'b0;
            content_in = 1'b0;
            count_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comment_ff <= 1'b0;
         paren_ff   <= 1'b0;
         content_ff <= 1'b0;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
      end else if (cmd.accept) begin
         comment_ff <= comment_in;
         paren_ff   <= paren_in;
         content_ff <= content_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         total_ff <= total_in;
         char_ff  <= char_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && wr_en) begin
         space_mem[count_ff[IDX_W-1:0]] <= req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= space_mem[idx_ff];
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.accept) begin
         idx_in = '0;
      end else if (cmd.load_sp) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // result register
   assign out_free = !valid_ff || !rsp_stall;
   assign load     = cmd.load_sp || cmd.load_ch || cmd.load_nl;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      last_in  = last_ff;
      flag_in  = flag_ff;
      if (load) begin
         valid_in = 1'b1;
         end_in   = cmd.load_nl;
         last_in  = cmd.load_ch || cmd.load_nl;
         flag_in  = ovf_ff;
         if (cmd.load_sp) begin
            byte_in = rd_data_ff;
         end else if (cmd.load_ch) begin
            byte_in = char_ff;
         end else begin
            byte_in = CH_NEWLINE;
         end
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
      last_ff <= last_in;
      flag_ff <= flag_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_line_end = end_ff;
   assign rsp_run_last = last_ff;
   assign rsp_overflow = flag_ff;

   assign status.emit_char   = emit_char;
   assign status.emit_nl     = emit_nl;
   assign status.has_pending = (count_ff != '0);
   assign status.last_space  = ((CNT_W'(idx_ff) + CNT_W'(1)) == total_ff);
   assign status.out_free    = out_free;

endmodule

`default_nettype wire

FILE: rtl/core/gcode_comment_stripper_unit.sv
// Top level of the G-code comment stripper: controller plus datapath.
//
//   channel | direction | transfer when       | payload
//   req_    | in        | req_valid & !stall | in_byte, end_of_stream
//   rsp_    | out       | rsp_valid & !stall | out_byte, line_end, overflow, run_last
//
// An input byte that releases nothing is only accepted; a kept character
// is then loaded via ST_SEND_CH, a separator via ST_SEND_NL. Each held
// whitespace byte takes a registered read of the whitespace store, then
// the result register load. Synchronous active-high reset clears line state,
// the overflow flag and the result valid. A stall on rsp_ holds the sequence.
`default_nettype none

module gcode_comment_stripper_unit
   import gcs_pkg::*;
#(
   parameter int unsigned SPACE_DEPTH = SPACE_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_end_of_stream,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_line_end,
   output logic            rsp_overflow,
   output logic            rsp_run_last
);

   gcs_cmd_type    cmd;
   gcs_status_type status;

   gcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gcs_dp #(
      .SPACE_DEPTH (SPACE_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_line_end      (rsp_line_end),
      .rsp_overflow      (rsp_overflow),
      .rsp_run_last      (rsp_run_last)
   );

endmodule

`default_nettype wire
